>>> rtl/core/wibs_pkg.sv
//------------------------------------------------------------------------------
// wibs_pkg
// Shared codes and widths for the weighted address-list scorer.
//------------------------------------------------------------------------------
`default_nettype none
package wibs_pkg;

	// Request commands
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	// Verdict codes
	localparam logic [1:0] VERDICT_FAIL = 2'd0;
	localparam logic [1:0] VERDICT_SOFT = 2'd1;
	localparam logic [1:0] VERDICT_HARD = 2'd2;
	localparam logic [1:0] VERDICT_NONE = 2'd3;

	// Status codes
	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	// Register indexes
	localparam logic [2:0] REG_HARD_LIMIT = 3'd0;
	localparam logic [2:0] REG_SOFT_LIMIT = 3'd1;
	localparam logic [2:0] REG_WEIGHT_0   = 3'd2;
	localparam logic [2:0] REG_WEIGHT_1   = 3'd3;
	localparam logic [2:0] REG_WEIGHT_2   = 3'd4;
	localparam logic [2:0] REG_WEIGHT_3   = 3'd5;

	// Field widths
	localparam int ADDR_W   = 32;
	localparam int LIMIT_W  = 13;
	localparam int WEIGHT_W = 11;
	localparam int SCORE_W  = 13;
	localparam int MAX_LISTS = 4;

	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [SCORE_W-1:0]  score_t;

endpackage
`default_nettype wire

>>> rtl/core/weighted_ip_blocklist_scorer.sv
//------------------------------------------------------------------------------
// weighted_ip_blocklist_scorer
// Sorted IPv4 address lists in one memory bank each; insert keeps order,
// query binary-searches all banks in parallel and grades the weighted score.
//------------------------------------------------------------------------------
// Query: each search step passes S_RD then S_EV until every bank range is empty, then S_FIN.
// Insert: search as above, then S_SHRD and S_SHWR per entry moved up, and S_SHRD for the final write.
// Search steps and shifts wait on the registered read of each bank.
// Result lands in the same cycle busy drops; a refused insert answers in the cycle after start.
// Reset clears fills, weights and control and sets both limits to 1; memory contents are left as is.
//------------------------------------------------------------------------------
`default_nettype none
module weighted_ip_blocklist_scorer
	import wibs_pkg::*;
#(
	parameter int LIST_COUNT = 4,
	parameter int LIST_DEPTH = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output      logic                busy,
	input  wire logic                command,
	input  wire logic [1:0]          list_select,
	input  wire logic [ADDR_W-1:0]   address,
	input  wire logic                cfg_write,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [LIMIT_W-1:0]  cfg_data,
	output      logic                done,
	output      logic                status,
	output      logic [1:0]          verdict,
	output      logic [SCORE_W-1:0]  score,
	output      logic [3:0]          match_mask
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = AW + 1;
	localparam int BW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EV   = 3'd2;
	localparam logic [2:0] S_SHRD = 3'd3;
	localparam logic [2:0] S_SHWR = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]         state_q;
	logic               cmd_q;
	logic [BW-1:0]      sel_q;
	addr_t              addr_q;
	logic [CW-1:0]      fill_q  [LIST_COUNT];
	logic [CW-1:0]      lo_q    [LIST_COUNT];
	logic [CW-1:0]      hi_q    [LIST_COUNT];
	logic [CW-1:0]      mid_s1  [LIST_COUNT];
	logic [LIST_COUNT-1:0] act_s1;
	logic [LIST_COUNT-1:0] found_q;
	logic [CW-1:0]      sp_q;
	logic [LIMIT_W-1:0] hard_q, soft_q;
	weight_t            weight_q [MAX_LISTS];

	// Memory port signals
	logic [AW-1:0]      rd_addr [LIST_COUNT];
	addr_t              rd_data [LIST_COUNT];
	logic [LIST_COUNT-1:0] wr_en;
	logic [AW-1:0]      wr_addr;
	addr_t              wr_data;

	logic [CW-1:0]      mid     [LIST_COUNT];
	logic [LIST_COUNT-1:0] active;
	logic               ins_ok;
	logic [CW-1:0]      pos;
	logic [CW-1:0]      sp_dec;
	score_t             sum;

	assign busy   = (state_q != S_IDLE);
	assign ins_ok = ({1'b0, list_select} < 3'(LIST_COUNT))
		&& (fill_q[list_select[BW-1:0]] < CW'(LIST_DEPTH));
	assign pos    = lo_q[sel_q];
	assign sp_dec = sp_q - CW'(1);

	// Midpoints and read addresses per bank
	always_comb begin
		for (int b = 0; b < LIST_COUNT; b++) begin
			mid[b]    = lo_q[b] + ((hi_q[b] - lo_q[b]) >> 1);
			active[b] = (lo_q[b] < hi_q[b]);
			if (state_q == S_SHRD)
				rd_addr[b] = sp_dec[AW-1:0];
			else
				rd_addr[b] = mid[b][AW-1:0];
		end
	end

	// Writes go only to the insert target bank
	always_comb begin
		wr_en   = '0;
		wr_addr = sp_q[AW-1:0];
		wr_data = rd_data[sel_q];
		if (state_q == S_SHWR) begin
			wr_en[sel_q] = 1'b1;
		end else if (state_q == S_SHRD && sp_q == pos) begin
			wr_en[sel_q] = 1'b1;
			wr_addr      = pos[AW-1:0];
			wr_data      = addr_q;
		end
	end

	// Weighted score of matching lists
	always_comb begin
		sum = '0;
		for (int b = 0; b < LIST_COUNT; b++)
			if (found_q[b])
				sum = sum + SCORE_W'(weight_q[b]);
	end

	// Address banks
	for (genvar g = 0; g < LIST_COUNT; g++) begin : g_bank
		addr_t mem [LIST_DEPTH];
		always_ff @(posedge clk) begin
			if (wr_en[g])
				mem[wr_addr] <= wr_data;
			rd_data[g] <= mem[rd_addr[g]];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_q <= LIMIT_W'(1);
			soft_q <= LIMIT_W'(1);
			for (int i = 0; i < MAX_LISTS; i++)
				weight_q[i] <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_HARD_LIMIT: hard_q <= cfg_data;
				REG_SOFT_LIMIT: soft_q <= cfg_data;
				REG_WEIGHT_0:   weight_q[0] <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_1:   weight_q[1] <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_2:   weight_q[2] <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_3:   weight_q[3] <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Search and shift sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done       <= 1'b0;
			status     <= STATUS_DONE;
			verdict    <= VERDICT_FAIL;
			score      <= '0;
			match_mask <= '0;
			cmd_q      <= CMD_INSERT;
			sel_q      <= '0;
			addr_q     <= '0;
			found_q    <= '0;
			act_s1     <= '0;
			sp_q       <= '0;
			for (int b = 0; b < LIST_COUNT; b++) begin
				fill_q[b] <= '0;
				lo_q[b]   <= '0;
				hi_q[b]   <= '0;
				mid_s1[b] <= '0;
			end
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= command;
						sel_q   <= list_select[BW-1:0];
						addr_q  <= address;
						found_q <= '0;
						for (int b = 0; b < LIST_COUNT; b++) begin
							lo_q[b] <= '0;
							hi_q[b] <= (command == CMD_QUERY
								|| list_select == 2'(b)) ? fill_q[b] : '0;
						end
						if (command == CMD_INSERT && !ins_ok) begin
							status     <= STATUS_REFUSED;
							verdict    <= VERDICT_NONE;
							score      <= '0;
							match_mask <= '0;
							done       <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					act_s1 <= active;
					for (int b = 0; b < LIST_COUNT; b++)
						mid_s1[b] <= mid[b];
					if (active == '0) begin
						sp_q    <= fill_q[sel_q];
						state_q <= (cmd_q == CMD_INSERT) ? S_SHRD : S_FIN;
					end else begin
						state_q <= S_EV;
					end
				end
				S_EV: begin
					for (int b = 0; b < LIST_COUNT; b++) begin
						if (act_s1[b]) begin
							if (rd_data[b] <= addr_q)
								lo_q[b] <= mid_s1[b] + CW'(1);
							else
								hi_q[b] <= mid_s1[b];
							if (rd_data[b] == addr_q)
								found_q[b] <= 1'b1;
						end
					end
					state_q <= S_RD;
				end
				S_SHRD: begin
					if (sp_q == pos) begin
						fill_q[sel_q] <= fill_q[sel_q] + CW'(1);
						state_q       <= S_FIN;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					sp_q    <= sp_dec;
					state_q <= S_SHRD;
				end
				S_FIN: begin
					done <= 1'b1;
					if (cmd_q == CMD_INSERT) begin
						status     <= STATUS_DONE;
						verdict    <= VERDICT_NONE;
						score      <= '0;
						match_mask <= '0;
					end else begin
						status     <= STATUS_DONE;
						score      <= sum;
						match_mask <= 4'(found_q);
						if (sum >= hard_q)
							verdict <= VERDICT_HARD;
						else if (sum >= soft_q)
							verdict <= VERDICT_SOFT;
						else
							verdict <= VERDICT_FAIL;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[sel_q] <= CW'(LIST_DEPTH)) else $error("list fill overflow");
	a_shift_above: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHWR) |-> (sp_q > pos)) else $error("shift below insert point");
	a_insert_res: assert property (@(posedge clk) disable iff (!arst_n)
		(done && verdict == VERDICT_NONE) |-> (score == '0 && match_mask == '0))
		else $error("insert result carries score");

endmodule
`default_nettype wire
